FILE: design/assert_macros.svh
// Assertion macros for the timed event queue, included by the top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TEVQ_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define TEVQ_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`define TEVQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define TEVQ_ASSERT(lbl, cond, msg)
`define TEVQ_ASSERT_IMPL(lbl, pre, post, msg)
`define TEVQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: design/tevq_pkg.sv
// Types and constants for the timed event queue.
`timescale 1ns / 1ps
package tevq_pkg;
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int TIME_W = 32;
	localparam int HANDLE_W = 16;
	localparam int FUNC_W = 2;
	localparam int STATUS_W = 2;
	localparam int IN_DATA_W = 80;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD = 2'd0,
		FUNC_POLL = 2'd1,
		FUNC_FINISH = 2'd2
	} tevq_func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2
	} tevq_status_t;

	typedef struct packed {
		logic [TIME_W-1:0] ev_time;
		logic [HANDLE_W-1:0] handle;
	} tevq_entry_t;

	typedef struct packed {
		logic ins;
		logic pop;
		tevq_entry_t entry;
	} tevq_cmd_t;
endpackage

FILE: design/tevq_cell.sv
// One slot of the sorted event chain, shifting toward its neighbors on insert and pop.
`timescale 1ns / 1ps
module tevq_cell
	import tevq_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CNT_W = 7
) (
	input logic clk,
	input logic [CNT_W-1:0] count,
	input tevq_cmd_t cmd,
	input tevq_entry_t left_entry,
	input logic left_gt,
	input tevq_entry_t right_entry,
	output tevq_entry_t cur_entry,
	output logic gt
);
	tevq_entry_t entry_q;
	logic occupied;
	logic at_tail;

	assign occupied = CNT_W'(IDX) < count;
	assign at_tail = CNT_W'(IDX) == count;
	assign gt = occupied && (entry_q.ev_time > cmd.entry.ev_time);
	assign cur_entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (gt || at_tail) begin
				entry_q <= cmd.entry;
			end
		end else if (cmd.pop) begin
			entry_q <= right_entry;
		end
	end
endmodule

FILE: design/tevq_top.sv
// Timed event queue: an operation is registered, then completed into a result word.
// The first stage registers the operation and the saturated reschedule time; the second
// updates the chain of cells in parallel and loads the output register.
// No new word is accepted while one is in the first stage or an untaken result is held.
// Reset (arst_n low, asynchronous) empties the queue and clears all handshake state.
`timescale 1ns / 1ps
module timed_event_queue_top
	import tevq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// handle [15:0], time_req [47:16], offset [79:48]
	input logic [IN_DATA_W-1:0] s_tdata,
	// func [1:0]
	input logic [FUNC_W-1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// status [1:0], due [2], due_handle [18:3], zero fill above
	output logic [OUT_DATA_W-1:0] m_tdata
);
	`include "assert_macros.svh"

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [HANDLE_W-1:0] in_handle;
	logic [TIME_W-1:0] in_time;
	logic [TIME_W-1:0] in_offset;
	logic [TIME_W:0] sat_sum;
	logic [TIME_W-1:0] eff_time;
	logic s_fire;

	logic pend_s1;
	tevq_func_t func_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic [TIME_W-1:0] time_s1;
	logic retire_s1;

	logic [CNT_W-1:0] count_q;
	logic full;
	logic ins_req;
	logic pop_ok;
	tevq_cmd_t cmd;
	tevq_status_t status_d;

	logic m_tvalid_q;
	tevq_status_t status_q;
	logic due_q;
	logic [HANDLE_W-1:0] due_handle_q;

	tevq_entry_t cur [QUEUE_DEPTH];
	logic gt_v [QUEUE_DEPTH];

	assign in_handle = s_tdata[HANDLE_W-1:0];
	assign in_time = s_tdata[HANDLE_W+TIME_W-1:HANDLE_W];
	assign in_offset = s_tdata[HANDLE_W+2*TIME_W-1:HANDLE_W+TIME_W];
	assign sat_sum = {1'b0, in_time} + {1'b0, in_offset};
	assign eff_time = (s_tuser == FUNC_FINISH) ?
		(sat_sum[TIME_W] ? {TIME_W{1'b1}} : sat_sum[TIME_W-1:0]) : in_time;

	assign s_tready = !pend_s1 && (!m_tvalid_q || m_tready);
	assign s_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= s_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			func_s1 <= tevq_func_t'(s_tuser);
			handle_s1 <= in_handle;
			time_s1 <= eff_time;
			retire_s1 <= in_offset == '0;
		end
	end

	assign full = count_q == CNT_W'(QUEUE_DEPTH);

	always_comb begin
		ins_req = 1'b0;
		pop_ok = 1'b0;
		status_d = ST_NONE;
		unique case (func_s1)
			FUNC_ADD: begin
				ins_req = 1'b1;
				status_d = full ? ST_FULL : ST_OK;
			end
			FUNC_POLL: begin
				pop_ok = (count_q != '0) && (cur[0].ev_time == time_s1);
				status_d = pop_ok ? ST_OK : ST_NONE;
			end
			FUNC_FINISH: begin
				ins_req = !retire_s1;
				status_d = (!retire_s1 && full) ? ST_FULL : ST_OK;
			end
			default: begin
				status_d = ST_NONE;
			end
		endcase
	end

	assign cmd.ins = pend_s1 && ins_req && !full;
	assign cmd.pop = pend_s1 && pop_ok;
	assign cmd.entry.ev_time = time_s1;
	assign cmd.entry.handle = handle_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		tevq_entry_t left_e;
		tevq_entry_t right_e;
		logic left_g;
		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_g = 1'b0;
		end else begin : g_body
			assign left_e = cur[i-1];
			assign left_g = gt_v[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = cur[i];
		end else begin : g_inner
			assign right_e = cur[i+1];
		end
		tevq_cell #(
			.IDX(i),
			.CNT_W(CNT_W)
		) u_cell (
			.clk(clk),
			.count(count_q),
			.cmd(cmd),
			.left_entry(left_e),
			.left_gt(left_g),
			.right_entry(right_e),
			.cur_entry(cur[i]),
			.gt(gt_v[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pend_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			status_q <= status_d;
			due_q <= pop_ok;
			due_handle_q <= pop_ok ? cur[0].handle : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(OUT_DATA_W - STATUS_W - 1 - HANDLE_W){1'b0}},
		due_handle_q, due_q, status_q};

	`TEVQ_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "event count above depth")
	`TEVQ_ASSERT_IMPL(a_out_free, pend_s1, !m_tvalid_q, "result register busy when operation completes")
	`TEVQ_ASSERT_NEXT(a_pop_count, cmd.pop, count_q == $past(count_q) - CNT_W'(1), "pop did not decrement count")
	`TEVQ_ASSERT_IMPL(a_due_ok, m_tvalid_q && due_q, status_q == ST_OK, "due word without ok status")
endmodule
